FILE: sv/prjq_pkg.sv
`timescale 1ns / 1ps

package prjq_pkg;

    typedef enum logic [2:0] {
        CMD_ENQUEUE   = 3'd0,
        CMD_SELECT    = 3'd1,
        CMD_COMPLETED = 3'd2,
        CMD_FAILED    = 3'd3,
        CMD_SKIPPED   = 3'd4,
        CMD_READ      = 3'd5,
        CMD_CLEAR     = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_CAPACITY  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        JS_PENDING   = 3'd0,
        JS_RUNNING   = 3'd1,
        JS_COMPLETED = 3'd2,
        JS_FAILED    = 3'd3,
        JS_SKIPPED   = 3'd4
    } t_jstate;

    localparam logic [4:0] CAP_RESET = 5'd16;
    localparam int         APB_AW    = 3;
    localparam logic [APB_AW-1:0] ADDR_CAPACITY = 3'd0;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [31:0]        job_tag;
        logic signed [15:0] priority_req;
        logic [7:0]         try_limit;
        logic [31:0]        job_id;
        logic [3:0]         entry_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        result_id;
        logic [31:0]        result_tag;
        logic signed [15:0] result_priority;
        logic [7:0]         result_attempts;
        logic [7:0]         result_try_limit;
        logic [2:0]         result_state;
        logic [4:0]         job_count;
    } t_out_item;

    typedef struct packed {
        logic [31:0]        id;
        logic [31:0]        tag;
        logic signed [15:0] prio;
        logic [7:0]         attempts;
        logic [7:0]         limit;
        logic [2:0]         jstate;
    } t_entry;

endpackage

FILE: sv/priority_retry_job_queue_top.sv
`timescale 1ns / 1ps

// Priority job table with retry limits, one command per item over a valid/ready
// pair, results on a second valid/ready pair, capacity set through an APB port.
// Entries live in a single-port-read memory of TABLE_DEPTH rows. Enqueue, clear
// and invalid commands answer in the cycle after the item is accepted;
// read entry first waits in S_RDWAIT for the memory read (unless the index is
// not held); select and the mark commands scan the held jobs one row per cycle
// via the memory read port, then write back the found row, answering at once
// on an empty table. The block takes the next item after the result is taken.
module priority_retry_job_queue_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  prjq_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output prjq_pkg::t_out_item            o_out_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prjq_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import prjq_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_RDWAIT = 5'b00100,
        S_FINISH = 5'b01000,
        S_OUT    = 5'b10000
    } t_fsm;

    t_fsm        r_fsm, n_fsm;
    logic [4:0]  r_cap;
    logic [CW-1:0] r_held, n_held;
    logic [31:0] r_next_id, n_next_id;
    t_in_item    r_req, n_req;
    t_out_item   r_out, n_out;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_bidx, n_bidx;
    t_entry      r_best, n_best;
    logic        r_found, n_found;

    t_entry      mem [TABLE_DEPTH];
    t_entry      r_rdata;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    t_entry      wr_data;

    logic        accept;
    logic        full;
    logic        last;
    logic        cand;
    logic        better;
    t_entry      upd;
    t_out_item   blank;

    assign o_in_ready  = (r_fsm == S_IDLE);
    assign o_out_valid = (r_fsm == S_OUT);
    assign o_out_item  = r_out;
    assign accept      = i_in_valid && o_in_ready;
    assign pready      = 1'b1;
    assign prdata      = (paddr == ADDR_CAPACITY) ? {27'd0, r_cap} : 32'd0;

    assign full = (32'(r_held) >= 32'(r_cap)) || (r_held == CW'(TABLE_DEPTH));
    assign last = (CW'(r_ptr) == CW'(r_held - CW'(1)));
    assign cand = (r_rdata.jstate == JS_PENDING) && (r_rdata.attempts < r_rdata.limit);
    assign better = !r_found || (r_rdata.prio > r_best.prio) ||
                    ((r_rdata.prio == r_best.prio) && (r_rdata.id < r_best.id));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
            r_cap <= pwdata[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_comb begin
        n_fsm     = r_fsm;
        n_held    = r_held;
        n_next_id = r_next_id;
        n_req     = r_req;
        n_out     = r_out;
        n_ptr     = r_ptr;
        n_bidx    = r_bidx;
        n_best    = r_best;
        n_found   = r_found;
        rd_addr   = AW'(r_ptr + AW'(1));
        wr_en     = 1'b0;
        wr_addr   = r_bidx;
        wr_data   = r_best;
        upd       = r_best;
        blank     = '0;
        blank.job_count = 5'(r_held);

        unique case (r_fsm)
            S_IDLE: begin
                rd_addr = '0;
                if (accept) begin
                    n_req   = i_in_item;
                    n_out   = blank;
                    n_ptr   = '0;
                    n_found = 1'b0;
                    n_fsm   = S_OUT;
                    unique case (t_cmd'(i_in_item.cmd))
                        CMD_ENQUEUE: begin
                            if (i_in_item.job_tag == 32'd0) begin
                                n_out.status = ST_INVALID;
                            end else if (full) begin
                                n_out.status = ST_CAPACITY;
                            end else begin
                                wr_en            = 1'b1;
                                wr_addr          = AW'(r_held);
                                wr_data.id       = r_next_id;
                                wr_data.tag      = i_in_item.job_tag;
                                wr_data.prio     = i_in_item.priority_req;
                                wr_data.attempts = 8'd0;
                                wr_data.limit    = (i_in_item.try_limit == 8'd0) ?
                                                   8'd1 : i_in_item.try_limit;
                                wr_data.jstate   = JS_PENDING;
                                n_held           = CW'(r_held + CW'(1));
                                n_next_id        = r_next_id + 32'd1;
                                n_out.result_id  = r_next_id;
                                n_out.job_count  = 5'(n_held);
                            end
                        end
                        CMD_SELECT, CMD_COMPLETED, CMD_FAILED, CMD_SKIPPED: begin
                            if (r_held == '0) begin
                                n_out.status = (t_cmd'(i_in_item.cmd) == CMD_SELECT) ?
                                               ST_EMPTY : ST_NOT_FOUND;
                            end else begin
                                n_fsm = S_SCAN;
                            end
                        end
                        CMD_READ: begin
                            if (32'(i_in_item.entry_index) >= 32'(r_held)) begin
                                n_out.status = ST_NOT_FOUND;
                            end else begin
                                rd_addr = AW'(32'(i_in_item.entry_index));
                                n_fsm   = S_RDWAIT;
                            end
                        end
                        CMD_CLEAR: begin
                            n_held          = '0;
                            n_next_id       = 32'd1;
                            n_out.job_count = 5'd0;
                        end
                        default: begin
                            n_out.status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (t_cmd'(r_req.cmd) == CMD_SELECT) begin
                    if (cand && better) begin
                        n_best  = r_rdata;
                        n_bidx  = r_ptr;
                        n_found = 1'b1;
                    end
                end else if (!r_found && r_rdata.id == r_req.job_id) begin
                    n_best  = r_rdata;
                    n_bidx  = r_ptr;
                    n_found = 1'b1;
                end
                n_ptr = AW'(r_ptr + AW'(1));
                if (last) begin
                    n_fsm = S_FINISH;
                end
            end
            S_RDWAIT: begin
                n_out.result_id        = r_rdata.id;
                n_out.result_tag       = r_rdata.tag;
                n_out.result_priority  = r_rdata.prio;
                n_out.result_attempts  = r_rdata.attempts;
                n_out.result_try_limit = r_rdata.limit;
                n_out.result_state     = r_rdata.jstate;
                n_fsm                  = S_OUT;
            end
            S_FINISH: begin
                n_fsm = S_OUT;
                unique case (t_cmd'(r_req.cmd))
                    CMD_SELECT: begin
                        upd.jstate   = JS_RUNNING;
                        upd.attempts = r_best.attempts + 8'd1;
                    end
                    CMD_COMPLETED: upd.jstate = JS_COMPLETED;
                    CMD_FAILED: begin
                        upd.jstate = (r_best.attempts < r_best.limit) ? JS_PENDING : JS_FAILED;
                    end
                    default: upd.jstate = JS_SKIPPED;
                endcase
                if (!r_found) begin
                    n_out.status = (t_cmd'(r_req.cmd) == CMD_SELECT) ? ST_EMPTY : ST_NOT_FOUND;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = upd;
                    if (t_cmd'(r_req.cmd) == CMD_SELECT) begin
                        n_out.result_id        = upd.id;
                        n_out.result_tag       = upd.tag;
                        n_out.result_priority  = upd.prio;
                        n_out.result_attempts  = upd.attempts;
                        n_out.result_try_limit = upd.limit;
                        n_out.result_state     = upd.jstate;
                    end
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_fsm = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= S_IDLE;
            r_held    <= '0;
            r_next_id <= 32'd1;
            r_found   <= 1'b0;
        end else begin
            r_fsm     <= n_fsm;
            r_held    <= n_held;
            r_next_id <= n_next_id;
            r_found   <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_out  <= n_out;
        r_ptr  <= n_ptr;
        r_bidx <= n_bidx;
        r_best <= n_best;
    end

endmodule

FILE: tb/sv/priority_retry_job_queue_top_test.sv
`timescale 1ns / 1ps

module priority_retry_job_queue_top_test;

    import prjq_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 115;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;

    localparam logic [2:0]        CMD_UNUSED    = 3'd7;
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED = 3'd4;

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item want;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // job table mirror
    t_entry      jobs [TABLE_DEPTH];
    int          held;
    logic [31:0] next_id;
    logic [4:0]  cap_reg;

    t_out_item   want_q [$];
    t_out_item   head;
    dir_row_t    dir_rows [$];
    int          mismatches = 0;
    int          cycle_cnt = 0;
    int          burst_left = 4;
    bit          tx_gappy = 1'b1;
    int          clear_pct = 5;
    int          rx_mode = 0;
    bit          hold_req = 1'b0;
    int          hold_cnt;
    int          rx_tick = 0;

    priority_retry_job_queue_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < 200) begin
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_cnt, what, got, want);
        end
        mismatches++;
    endtask

    function automatic void put_entry(inout t_out_item r, input t_entry e);
        r.result_id        = e.id;
        r.result_tag       = e.tag;
        r.result_priority  = e.prio;
        r.result_attempts  = e.attempts;
        r.result_try_limit = e.limit;
        r.result_state     = e.jstate;
    endfunction

    task automatic job_table_apply(input t_in_item it, output t_out_item r);
        int lim;
        int pick;
        int pos;
        r = '0;
        r.status = ST_OK;
        lim = (cap_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(cap_reg);
        pick = -1;
        pos = -1;
        case (it.cmd)
            CMD_ENQUEUE: begin
                if (it.job_tag == '0) begin
                    r.status = ST_INVALID;
                end else if (held >= lim) begin
                    r.status = ST_CAPACITY;
                end else begin
                    jobs[held].id       = next_id;
                    jobs[held].tag      = it.job_tag;
                    jobs[held].prio     = it.priority_req;
                    jobs[held].attempts = '0;
                    jobs[held].limit    = (it.try_limit == '0) ? 8'd1 : it.try_limit;
                    jobs[held].jstate   = JS_PENDING;
                    r.result_id = next_id;
                    held++;
                    next_id = next_id + 32'd1;
                end
            end
            CMD_SELECT: begin
                for (int i = 0; i < held; i++) begin
                    if (jobs[i].jstate == JS_PENDING && jobs[i].attempts < jobs[i].limit) begin
                        if (pick < 0 || $signed(jobs[i].prio) > $signed(jobs[pick].prio) ||
                            ($signed(jobs[i].prio) == $signed(jobs[pick].prio) &&
                             jobs[i].id < jobs[pick].id)) begin
                            pick = i;
                        end
                    end
                end
                if (pick < 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    jobs[pick].jstate   = JS_RUNNING;
                    jobs[pick].attempts = jobs[pick].attempts + 8'd1;
                    put_entry(r, jobs[pick]);
                end
            end
            CMD_COMPLETED, CMD_FAILED, CMD_SKIPPED: begin
                for (int i = held - 1; i >= 0; i--) begin
                    if (jobs[i].id == it.job_id) pos = i;
                end
                if (pos < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (it.cmd == CMD_COMPLETED) begin
                    jobs[pos].jstate = JS_COMPLETED;
                end else if (it.cmd == CMD_FAILED) begin
                    jobs[pos].jstate = (jobs[pos].attempts < jobs[pos].limit) ?
                                       JS_PENDING : JS_FAILED;
                end else begin
                    jobs[pos].jstate = JS_SKIPPED;
                end
            end
            CMD_READ: begin
                if (int'(it.entry_index) >= held) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    put_entry(r, jobs[it.entry_index]);
                end
            end
            CMD_CLEAR: begin
                held = 0;
                next_id = 32'd1;
            end
            default: begin
                r.status = ST_INVALID;
            end
        endcase
        r.job_count = 5'(held);
    endtask

    function automatic t_in_item draw_cmd();
        t_in_item it;
        int w;
        it.job_tag      = $urandom;
        it.priority_req = 16'($urandom);
        it.try_limit    = 8'($urandom);
        it.job_id       = $urandom;
        it.entry_index  = 4'($urandom);
        w = $urandom_range(0, 99);
        if (w < clear_pct) begin
            it.cmd = CMD_CLEAR;
        end else if (w < clear_pct + 2) begin
            it.cmd = CMD_UNUSED;
        end else begin
            w = $urandom_range(0, 99);
            if (w < 32)      it.cmd = CMD_ENQUEUE;
            else if (w < 56) it.cmd = CMD_SELECT;
            else if (w < 64) it.cmd = CMD_COMPLETED;
            else if (w < 78) it.cmd = CMD_FAILED;
            else if (w < 84) it.cmd = CMD_SKIPPED;
            else             it.cmd = CMD_READ;
        end
        if (it.cmd == CMD_ENQUEUE) begin
            if ($urandom_range(0, 19) == 0) it.job_tag = '0;
            case ($urandom_range(0, 3))
                0, 1: it.priority_req = 16'(int'($urandom_range(0, 4)) - 2);
                2: it.priority_req = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                default: ;
            endcase
            if ($urandom_range(0, 4) < 3) it.try_limit = 8'($urandom_range(0, 3));
        end
        if (it.cmd == CMD_COMPLETED || it.cmd == CMD_FAILED || it.cmd == CMD_SKIPPED) begin
            w = $urandom_range(0, 9);
            if (w < 7)       it.job_id = $urandom_range(1, next_id);
            else if (w == 7) it.job_id = '0;
        end
        if (it.cmd == CMD_READ && $urandom_range(0, 3) != 0) begin
            it.entry_index = 4'($urandom_range(0, held));
        end
        return it;
    endfunction

    task automatic offer_cmd(input t_in_item it, input bit typed, input t_out_item typed_r);
        t_out_item pr;
        int gap;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        job_table_apply(it, pr);
        want_q.push_back(typed ? typed_r : pr);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            if (tx_gappy) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic await_results();
        i_in_valid <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle_idle();
        await_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input bit wr, input logic [APB_AW-1:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (wr) begin
            if (a == ADDR_CAPACITY) cap_reg = d[4:0];
        end else if (prdata[4:0] !== cap_reg) begin
            note_mismatch("capacity readback", 32'(prdata[4:0]), 32'(cap_reg));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cap_program(input logic [4:0] v);
        logic [31:0] d;
        d = $urandom;
        d[4:0] = v;
        apb_xfer(1'b1, ADDR_CAPACITY, d);
        apb_xfer(1'b0, ADDR_CAPACITY, '0);
    endtask

    task automatic add_row(input logic [2:0] cmd, input logic [31:0] tag,
                           input logic signed [15:0] prio, input logic [7:0] maxa,
                           input logic [31:0] id, input logic [3:0] idx, input bit typed,
                           input logic [2:0] st, input logic [31:0] rid,
                           input logic [4:0] cnt);
        dir_row_t row;
        row.it.cmd          = cmd;
        row.it.job_tag      = tag;
        row.it.priority_req = prio;
        row.it.try_limit    = maxa;
        row.it.job_id       = id;
        row.it.entry_index  = idx;
        row.typed           = typed;
        row.want            = '0;
        row.want.status     = st;
        row.want.result_id  = rid;
        row.want.job_count  = cnt;
        dir_rows.push_back(row);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            rx_tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold_cnt++;
                end
            end else begin
                case (rx_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 7) == 0);
                    default: i_out_ready <= ((rx_tick % 7) < 4);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (want_q.size() == 0) begin
                note_mismatch("result with nothing pending", 32'(o_out_item.status), '0);
            end else begin
                head = want_q.pop_front();
                if (o_out_item.status !== head.status)
                    note_mismatch("status", 32'(o_out_item.status), 32'(head.status));
                if (o_out_item.result_id !== head.result_id)
                    note_mismatch("result_id", o_out_item.result_id, head.result_id);
                if (o_out_item.result_tag !== head.result_tag)
                    note_mismatch("result_tag", o_out_item.result_tag, head.result_tag);
                if (o_out_item.result_priority !== head.result_priority)
                    note_mismatch("result_priority", 32'(o_out_item.result_priority),
                                  32'(head.result_priority));
                if (o_out_item.result_attempts !== head.result_attempts)
                    note_mismatch("result_attempts", 32'(o_out_item.result_attempts),
                                  32'(head.result_attempts));
                if (o_out_item.result_try_limit !== head.result_try_limit)
                    note_mismatch("result_try_limit", 32'(o_out_item.result_try_limit),
                                  32'(head.result_try_limit));
                if (o_out_item.result_state !== head.result_state)
                    note_mismatch("result_state", 32'(o_out_item.result_state),
                                  32'(head.result_state));
                if (o_out_item.job_count !== head.job_count)
                    note_mismatch("job_count", 32'(o_out_item.job_count), 32'(head.job_count));
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [4:0] cap_plan [PHASES];
        cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd8, 5'd16};
        cap_plan[7] = 5'($urandom_range(1, 16));
        held    = 0;
        next_id = 32'd1;
        cap_reg = CAP_RESET;

        add_row(CMD_SELECT, '0, '0, '0, '0, '0, 1'b1, ST_EMPTY, '0, 5'd0);
        add_row(CMD_READ, '0, '0, '0, '0, 4'd0, 1'b1, ST_NOT_FOUND, '0, 5'd0);
        add_row(CMD_COMPLETED, '0, '0, '0, 32'd1, '0, 1'b1, ST_NOT_FOUND, '0, 5'd0);
        add_row(CMD_ENQUEUE, '0, 16'sh0005, 8'd2, '0, '0, 1'b1, ST_INVALID, '0, 5'd0);
        add_row(CMD_UNUSED, 32'hFFFF_FFFF, 16'sh7FFF, 8'hFF, 32'hFFFF_FFFF, 4'hF, 1'b1,
                ST_INVALID, '0, 5'd0);
        add_row(CMD_ENQUEUE, 32'hFFFF_FFFF, 16'sh7FFF, 8'd0, '0, '0, 1'b1, ST_OK, 32'd1, 5'd1);
        add_row(CMD_ENQUEUE, 32'd1, 16'sh8000, 8'd255, '0, '0, 1'b1, ST_OK, 32'd2, 5'd2);
        add_row(CMD_ENQUEUE, 32'h5A5A_0000, 16'sh7FFF, 8'd3, '0, '0, 1'b1, ST_OK, 32'd3, 5'd3);
        add_row(CMD_SELECT, '0, '0, '0, '0, '0, 1'b0, ST_OK, '0, '0);
        add_row(CMD_SELECT, '0, '0, '0, '0, '0, 1'b0, ST_OK, '0, '0);
        add_row(CMD_FAILED, '0, '0, '0, 32'd1, '0, 1'b0, ST_OK, '0, '0);
        add_row(CMD_FAILED, '0, '0, '0, 32'd3, '0, 1'b0, ST_OK, '0, '0);
        add_row(CMD_SELECT, '0, '0, '0, '0, '0, 1'b0, ST_OK, '0, '0);
        add_row(CMD_SKIPPED, '0, '0, '0, 32'd3, '0, 1'b0, ST_OK, '0, '0);
        add_row(CMD_SELECT, '0, '0, '0, '0, '0, 1'b0, ST_OK, '0, '0);
        add_row(CMD_COMPLETED, '0, '0, '0, 32'd2, '0, 1'b0, ST_OK, '0, '0);
        add_row(CMD_SELECT, '0, '0, '0, '0, '0, 1'b1, ST_EMPTY, '0, 5'd3);
        add_row(CMD_COMPLETED, '0, '0, '0, 32'd3, '0, 1'b0, ST_OK, '0, '0);
        add_row(CMD_READ, '0, '0, '0, '0, 4'd0, 1'b0, ST_OK, '0, '0);
        add_row(CMD_READ, '0, '0, '0, '0, 4'd2, 1'b0, ST_OK, '0, '0);
        add_row(CMD_READ, '0, '0, '0, '0, 4'd3, 1'b1, ST_NOT_FOUND, '0, 5'd3);
        add_row(CMD_READ, '0, '0, '0, '0, 4'hF, 1'b1, ST_NOT_FOUND, '0, 5'd3);
        add_row(CMD_FAILED, '0, '0, '0, 32'hFFFF_FFFF, '0, 1'b1, ST_NOT_FOUND, '0, 5'd3);
        add_row(CMD_CLEAR, '0, '0, '0, '0, '0, 1'b1, ST_OK, '0, 5'd0);
        add_row(CMD_ENQUEUE, 32'hFFFF_FFFF, 16'sh0000, 8'd1, 32'hFFFF_FFFF, 4'hF, 1'b1,
                ST_OK, 32'd1, 5'd1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < dir_rows.size(); n++) begin
            offer_cmd(dir_rows[n].it, dir_rows[n].typed, dir_rows[n].want);
        end
        settle_idle();

        for (int p = 0; p < PHASES; p++) begin
            rx_mode   = p % 4;
            tx_gappy  = (p % 3) != 1;
            clear_pct = (p % 2 == 0) ? 1 : 5;
            cap_program(cap_plan[p]);
            if (p == 3) begin
                apb_xfer(1'b1, ADDR_UNMAPPED, $urandom);
                apb_xfer(1'b0, ADDR_CAPACITY, '0);
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == 20) hold_req = 1'b1;
                if (p == 5 && k == 50) await_results();
                offer_cmd(draw_cmd(), 1'b0, '0);
            end
            settle_idle();
        end

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
